@@ design/bvma_pkg.sv @@
// ----------------------------------------------------------------------------
// bvma_pkg - shared constants for the battery voltage moving average
// Register indexes, mode codes, conversion constants and datapath widths.
// ----------------------------------------------------------------------------
`default_nettype none

package bvma_pkg;

  // Default depth of the sample ring store
  localparam int MAX_WINDOW_DEF = 16;

  // Configuration port
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_ADDR_W-1:0] REG_MONITOR_EN = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_CAL_GAIN   = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_WINDOW_LEN = 2'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_CELL_COUNT = 2'd3;

  // Register widths and reset values
  localparam int GAIN_W = 16;
  localparam int WIN_W  = 5;
  localparam int CELL_W = 5;

  localparam logic [GAIN_W-1:0] GAIN_RST = 16'd4096;
  localparam logic [WIN_W-1:0]  WIN_RST  = 5'd1;
  localparam logic [CELL_W-1:0] CELL_RST = 5'd1;

  // Input item mode codes
  localparam int MODE_W = 2;
  localparam logic [MODE_W-1:0] MODE_INIT   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_RESEED = 2'd1;
  localparam logic [MODE_W-1:0] MODE_UPDATE = 2'd2;

  // Field widths
  localparam int ADC_W  = 10;
  localparam int VOLT_W = 16;

  // Conversion constants
  localparam int ADC_REF_MV = 3300;
  localparam int ADC_FULL   = 1023;
  localparam int DIV_RATIO  = 11;
  localparam int CELL_MV    = 3500;

  // Serial divider: dividend bits, divisor bits, cycle counter width
  localparam int DIV_W = 22;
  localparam int DD_W  = 10;
  localparam int CNT_W = 5;

  // Serial multiplier: multiplier bits and product width
  localparam int MUL_W  = 16;
  localparam int PROD_W = 32;

  // Millivolt quotient width (at most 3300)
  localparam int MV_W = 12;

endpackage

`default_nettype wire

@@ design/battery_voltage_moving_average.sv @@
// ----------------------------------------------------------------------------
// battery_voltage_moving_average - bit-serial battery voltage boxcar filter
// Scales ADC readings to calibrated millivolts and averages them over a ring.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream: in_tuser carries the mode, in_tdata the 10-bit ADC sample.
//   Result stream: out_tdata carries the voltage estimate in millivolts.
//   Configuration: cfg_wen/cfg_addr/cfg_wdata, written only while idle.
// Sequence (accept to result transfer), one item in flight at a time:
//   mode 3 or monitor disabled : straight to the output state.
//   modes 0 and 1, or window 1 : /1023 divide, then gain multiply.
//   mode 2, window w > 1       : divide, multiply, store write, position
//                                wrap by repeated subtraction of the window
//                                length, sum of w entries, divide for the mean.
//   Both divides use the shared bit-serial divider (one quotient bit per
//   cycle); the gain multiply uses the shift-add multiplier (one gain bit per
//   cycle).
// Reset clears the ring store (all entries read as zero), the write position
// and the voltage estimate; registers return to their documented defaults.
// The result sits in an output register: a new item is accepted while it
// waits, and a stalled receiver only holds the block once the next result
// is ready.
// ----------------------------------------------------------------------------
`default_nettype none

module battery_voltage_moving_average #(
  parameter int MAX_WINDOW = bvma_pkg::MAX_WINDOW_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  // configuration write port
  input  wire logic                            cfg_wen,
  input  wire logic [bvma_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [bvma_pkg::CFG_DATA_W-1:0] cfg_wdata,
  // input stream
  input  wire logic                            in_tvalid,
  output      logic                            in_tready,
  input  wire logic [15:0]                     in_tdata,   // [9:0] adc_sample
  input  wire logic [bvma_pkg::MODE_W-1:0]     in_tuser,   // [1:0] mode
  // result stream
  output      logic                            out_tvalid,
  input  wire logic                            out_tready,
  output      logic [15:0]                     out_tdata   // [15:0] voltage_mv
);

  // Derived sizes
  localparam int WMAX = (MAX_WINDOW < 31) ? MAX_WINDOW : 31;
  localparam int WW   = $clog2(WMAX + 1);
  localparam int AW   = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int CW   = (AW + 1 > WW) ? AW + 1 : WW;
  localparam int VW   = bvma_pkg::VOLT_W;
  localparam int SW   = VW + WW;

  // Sequencer states
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DIV   = 3'd1;
  localparam logic [2:0] S_MUL   = 3'd2;
  localparam logic [2:0] S_APPLY = 3'd3;
  localparam logic [2:0] S_MOD   = 3'd4;
  localparam logic [2:0] S_SUM   = 3'd5;
  localparam logic [2:0] S_OUT   = 3'd6;

  // Divider job codes
  localparam logic JOB_MV   = 1'b0;
  localparam logic JOB_MEAN = 1'b1;

  // Configuration registers
  logic                          mon_en_r;
  logic [bvma_pkg::GAIN_W-1:0]   gain_r;
  logic [bvma_pkg::WIN_W-1:0]    win_r;
  logic [bvma_pkg::CELL_W-1:0]   cell_r;

  // Control state
  logic [2:0]                    st_r, st_nxt;
  logic                          job_r, job_nxt;
  logic [bvma_pkg::CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [AW-1:0]                 pos_r, pos_nxt;
  logic [MAX_WINDOW-1:0]         vld_r, vld_nxt;
  logic [VW-1:0]                 seed_r, seed_nxt;
  logic [VW-1:0]                 cur_r, cur_nxt;
  logic [WW-1:0]                 rd_idx_r, rd_idx_nxt;
  logic                          rd_pend_r, rd_pend_nxt;
  logic                          out_valid_r, out_valid_nxt;

  // Datapath registers
  logic [bvma_pkg::MODE_W-1:0]   mode_r, mode_nxt;
  logic [bvma_pkg::DIV_W-1:0]    dq_r, dq_nxt;
  logic [bvma_pkg::DD_W-1:0]     dr_r, dr_nxt;
  logic [bvma_pkg::DD_W-1:0]     dd_r, dd_nxt;
  logic [bvma_pkg::PROD_W-1:0]   prod_r, prod_nxt;
  logic [VW-1:0]                 mcand_r, mcand_nxt;
  logic [bvma_pkg::MUL_W-1:0]    gsh_r, gsh_nxt;
  logic [VW-1:0]                 raw_r, raw_nxt;
  logic [CW-1:0]                 p_r, p_nxt;
  logic [SW-1:0]                 acc_r, acc_nxt;
  logic [VW-1:0]                 out_data_r, out_data_nxt;

  // Ring store
  logic [VW-1:0]                 mem [MAX_WINDOW];
  logic [VW-1:0]                 mem_q_r;
  logic                          vld_q_r;
  logic                          mem_we;
  logic [AW-1:0]                 rd_addr;

  // Helpers
  logic                          in_xfer;
  logic [WW-1:0]                 weff;
  logic [bvma_pkg::DD_W:0]       div_t, div_diff;
  logic                          div_ge;
  logic [bvma_pkg::MUL_W:0]      mul_sum;
  logic [16:0]                   cell_prod;
  logic [VW-1:0]                 cell_mv;
  logic [VW-1:0]                 mv16;
  logic [VW-1:0]                 rd_val;
  logic                          rd_issue;

  assign in_xfer    = in_tvalid && in_tready;
  assign in_tready  = (st_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // Effective window: zero counts as one, clamp to store depth
  always_comb begin
    if (win_r == '0) begin
      weff = WW'(1);
    end else if (32'(win_r) > 32'(WMAX)) begin
      weff = WW'(WMAX);
    end else begin
      weff = WW'(win_r);
    end
  end

  // Default voltage from cell count, saturated
  assign cell_prod = 17'(cell_r) * 17'(bvma_pkg::CELL_MV);
  assign cell_mv   = cell_prod[16] ? '1 : cell_prod[15:0];

  // One restoring divide step per cycle
  assign div_t    = {dr_r, dq_r[bvma_pkg::DIV_W-1]};
  assign div_ge   = (div_t >= {1'b0, dd_r});
  assign div_diff = div_t - {1'b0, dd_r};

  // One shift-add multiply step per cycle
  assign mul_sum = {1'b0, prod_r[bvma_pkg::PROD_W-1:bvma_pkg::MUL_W]}
                 + {1'b0, (gsh_r[0] ? mcand_r : '0)};

  // Millivolts: low quotient bits after the last /1023 step
  assign mv16 = {{(VW - bvma_pkg::MV_W){1'b0}}, dq_r[bvma_pkg::MV_W-2:0], div_ge};

  // Store read: entries not written since reseed read as the seed value
  assign rd_addr  = AW'(rd_idx_r);
  assign rd_val   = vld_q_r ? mem_q_r : seed_r;
  assign rd_issue = (rd_idx_r < weff);

  // Sequencer
  always_comb begin
    st_nxt        = st_r;
    job_nxt       = job_r;
    cnt_nxt       = cnt_r;
    pos_nxt       = pos_r;
    vld_nxt       = vld_r;
    seed_nxt      = seed_r;
    cur_nxt       = cur_r;
    rd_idx_nxt    = rd_idx_r;
    rd_pend_nxt   = rd_pend_r;
    out_valid_nxt = out_valid_r;
    mode_nxt      = mode_r;
    dq_nxt        = dq_r;
    dr_nxt        = dr_r;
    dd_nxt        = dd_r;
    prod_nxt      = prod_r;
    mcand_nxt     = mcand_r;
    gsh_nxt       = gsh_r;
    raw_nxt       = raw_r;
    p_nxt         = p_r;
    acc_nxt       = acc_r;
    out_data_nxt  = out_data_r;
    mem_we        = 1'b0;

    // result leaves the output register
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (st_r)
      S_IDLE: begin
        if (in_xfer) begin
          mode_nxt = in_tuser;
          case (in_tuser) inside
            bvma_pkg::MODE_INIT, bvma_pkg::MODE_RESEED, bvma_pkg::MODE_UPDATE: begin
              if (mon_en_r) begin
                // millivolts = sample * 3300 / 1023
                dq_nxt  = bvma_pkg::DIV_W'(in_tdata[bvma_pkg::ADC_W-1:0])
                        * bvma_pkg::DIV_W'(bvma_pkg::ADC_REF_MV);
                dr_nxt  = '0;
                dd_nxt  = bvma_pkg::DD_W'(bvma_pkg::ADC_FULL);
                cnt_nxt = bvma_pkg::CNT_W'(bvma_pkg::DIV_W - 1);
                job_nxt = JOB_MV;
                st_nxt  = S_DIV;
              end else begin
                cur_nxt = cell_mv;
                st_nxt  = S_OUT;
              end
            end
            default: begin
              // unused mode: report the current estimate unchanged
              st_nxt = S_OUT;
            end
          endcase
        end
      end

      S_DIV: begin
        dq_nxt = {dq_r[bvma_pkg::DIV_W-2:0], div_ge};
        dr_nxt = div_ge ? div_diff[bvma_pkg::DD_W-1:0] : div_t[bvma_pkg::DD_W-1:0];
        if (cnt_r == '0) begin
          if (job_r == JOB_MV) begin
            mcand_nxt = (mv16 << 3) + (mv16 << 1) + mv16;
            gsh_nxt   = gain_r;
            prod_nxt  = '0;
            cnt_nxt   = bvma_pkg::CNT_W'(bvma_pkg::MUL_W - 1);
            st_nxt    = S_MUL;
          end else begin
            cur_nxt = dq_nxt[VW-1:0];
            st_nxt  = S_OUT;
          end
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end

      S_MUL: begin
        prod_nxt = {mul_sum, prod_r[bvma_pkg::MUL_W-1:1]};
        gsh_nxt  = gsh_r >> 1;
        if (cnt_r == '0) begin
          // drop Q4.12 fraction and saturate to 16 bits
          raw_nxt = (prod_nxt[bvma_pkg::PROD_W-1:28] != '0) ? '1 : prod_nxt[27:12];
          st_nxt  = S_APPLY;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end

      S_APPLY: begin
        case (mode_r)
          bvma_pkg::MODE_RESEED: begin
            seed_nxt = raw_r;
            vld_nxt  = '0;
            pos_nxt  = '0;
            cur_nxt  = raw_r;
            st_nxt   = S_OUT;
          end
          bvma_pkg::MODE_UPDATE: begin
            if (weff == WW'(1)) begin
              cur_nxt = raw_r;
              st_nxt  = S_OUT;
            end else begin
              mem_we         = 1'b1;
              vld_nxt[pos_r] = 1'b1;
              p_nxt          = CW'(pos_r) + CW'(1);
              st_nxt         = S_MOD;
            end
          end
          default: begin
            cur_nxt = raw_r;
            st_nxt  = S_OUT;
          end
        endcase
      end

      S_MOD: begin
        // wrap next position into the window by repeated subtraction
        if (p_r >= CW'(weff)) begin
          p_nxt = p_r - CW'(weff);
        end else begin
          pos_nxt     = p_r[AW-1:0];
          rd_idx_nxt  = '0;
          rd_pend_nxt = 1'b0;
          acc_nxt     = '0;
          st_nxt      = S_SUM;
        end
      end

      S_SUM: begin
        // one entry per cycle, read data registered
        if (rd_issue) begin
          rd_idx_nxt = rd_idx_r + 1'b1;
        end
        rd_pend_nxt = rd_issue;
        if (rd_pend_r) begin
          acc_nxt = acc_r + SW'(rd_val);
        end
        if (!rd_issue && !rd_pend_r) begin
          dq_nxt  = bvma_pkg::DIV_W'(acc_r);
          dr_nxt  = '0;
          dd_nxt  = bvma_pkg::DD_W'(weff);
          cnt_nxt = bvma_pkg::CNT_W'(bvma_pkg::DIV_W - 1);
          job_nxt = JOB_MEAN;
          st_nxt  = S_DIV;
        end
      end

      S_OUT: begin
        if (!out_valid_r || out_tready) begin
          out_data_nxt  = cur_r;
          out_valid_nxt = 1'b1;
          st_nxt        = S_IDLE;
        end
      end

      default: begin
        st_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_IDLE;
      job_r       <= JOB_MV;
      cnt_r       <= '0;
      pos_r       <= '0;
      vld_r       <= '0;
      seed_r      <= '0;
      cur_r       <= '0;
      rd_idx_r    <= '0;
      rd_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
      mon_en_r    <= 1'b0;
      gain_r      <= bvma_pkg::GAIN_RST;
      win_r       <= bvma_pkg::WIN_RST;
      cell_r      <= bvma_pkg::CELL_RST;
    end else begin
      st_r        <= st_nxt;
      job_r       <= job_nxt;
      cnt_r       <= cnt_nxt;
      pos_r       <= pos_nxt;
      vld_r       <= vld_nxt;
      seed_r      <= seed_nxt;
      cur_r       <= cur_nxt;
      rd_idx_r    <= rd_idx_nxt;
      rd_pend_r   <= rd_pend_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wen) begin
        unique case (cfg_addr)
          bvma_pkg::REG_MONITOR_EN: mon_en_r <= cfg_wdata[0];
          bvma_pkg::REG_CAL_GAIN:   gain_r   <= cfg_wdata[bvma_pkg::GAIN_W-1:0];
          bvma_pkg::REG_WINDOW_LEN: win_r    <= cfg_wdata[bvma_pkg::WIN_W-1:0];
          bvma_pkg::REG_CELL_COUNT: cell_r   <= cfg_wdata[bvma_pkg::CELL_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    mode_r     <= mode_nxt;
    dq_r       <= dq_nxt;
    dr_r       <= dr_nxt;
    dd_r       <= dd_nxt;
    prod_r     <= prod_nxt;
    mcand_r    <= mcand_nxt;
    gsh_r      <= gsh_nxt;
    raw_r      <= raw_nxt;
    p_r        <= p_nxt;
    acc_r      <= acc_nxt;
    out_data_r <= out_data_nxt;
  end

  // Ring store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[pos_r] <= raw_r;
    end
    mem_q_r <= mem[rd_addr];
    vld_q_r <= vld_r[rd_addr];
  end

  // Checks
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> !in_tready)
    else $error("input accepted again while an item is in progress");

  a_div_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_DIV) |-> (dr_r < dd_r))
    else $error("divider remainder not below divisor");

  a_sum_index_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_SUM) |-> (rd_idx_r <= weff))
    else $error("summation index ran past the window");

  a_result_from_out_state: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(st_r == S_OUT))
    else $error("result presented outside the output state");

endmodule

`default_nettype wire

@@ bench/tb.sv @@
// ----------------------------------------------------------------------------
// tb - testbench for battery_voltage_moving_average
// Drives mode/sample items on the input stream and register settings on the
// write port. Each result is checked against an in-bench voltage predictor
// that tracks the ring store, the write position and the current estimate.
// ----------------------------------------------------------------------------
module tb;

  // Mode code that the block ignores
  localparam logic [bvma_pkg::MODE_W-1:0] MODE_NOP = 2'd3;

  localparam int HOLD_CYCLES = 400;
  localparam int CYCLE_LIMIT = 1500000;
  localparam int RAND_PHASES = 8;
  localparam int PHASE_ITEMS = 227;

  logic                            clk = 1'b0;
  logic                            rst_n;
  logic                            cfg_wen;
  logic [bvma_pkg::CFG_ADDR_W-1:0] cfg_addr;
  logic [bvma_pkg::CFG_DATA_W-1:0] cfg_wdata;
  logic                            in_tvalid;
  logic                            in_tready;
  logic [15:0]                     in_tdata;   // [9:0] adc_sample
  logic [bvma_pkg::MODE_W-1:0]     in_tuser;   // [1:0] mode
  logic                            out_tvalid;
  logic                            out_tready;
  logic [15:0]                     out_tdata;  // [15:0] voltage_mv

  // Predictor copy of registers and state
  logic                        mon_en_m = 1'b0;
  logic [bvma_pkg::GAIN_W-1:0] gain_m   = bvma_pkg::GAIN_RST;
  logic [bvma_pkg::WIN_W-1:0]  win_m    = bvma_pkg::WIN_RST;
  logic [bvma_pkg::CELL_W-1:0] cells_m  = bvma_pkg::CELL_RST;
  logic [15:0]                 store_m [bvma_pkg::MAX_WINDOW_DEF];
  logic [3:0]                  wpos_m   = '0;
  logic [15:0]                 volt_m   = '0;

  logic [15:0] volt_expected [$];
  logic [15:0] volt_head;
  int          errors = 0;
  int          items_sent = 0;
  int          results_seen = 0;
  int          settings_count = 0;
  int          cycle_count = 0;
  bit          idle_on = 1'b1;
  bit          hold_req = 1'b0;

  battery_voltage_moving_average dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wen    (cfg_wen),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #5 clk = ~clk;

  // Run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results pending", $time, volt_expected.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Voltage predictor: returns the estimate for one item and updates state
  function automatic logic [15:0] predict_voltage(
      input logic [bvma_pkg::MODE_W-1:0] mode,
      input logic [bvma_pkg::ADC_W-1:0]  adc);
    longint unsigned mv;
    longint unsigned scaled;
    int unsigned     w;
    int unsigned     sum;
    int unsigned     d;
    logic [15:0]     raw;
    if (mode == MODE_NOP) return volt_m;
    // no sense input: cell-count default in modes 0 to 2
    if (!mon_en_m) begin
      d = cells_m * bvma_pkg::CELL_MV;
      volt_m = (d > 65535) ? 16'hFFFF : d[15:0];
      return volt_m;
    end
    mv = adc;
    mv = (mv * bvma_pkg::ADC_REF_MV) / bvma_pkg::ADC_FULL;
    scaled = (mv * bvma_pkg::DIV_RATIO * gain_m) >> 12;
    raw = (scaled > 65535) ? 16'hFFFF : scaled[15:0];
    case (mode)
      bvma_pkg::MODE_INIT: begin
        volt_m = raw;
      end
      bvma_pkg::MODE_RESEED: begin
        foreach (store_m[i]) store_m[i] = raw;
        wpos_m = '0;
        volt_m = raw;
      end
      default: begin
        w = win_m;
        if (w == 0) w = 1;
        if (w > bvma_pkg::MAX_WINDOW_DEF) w = bvma_pkg::MAX_WINDOW_DEF;
        if (w == 1) begin
          volt_m = raw;
        end else begin
          // old position is written even if it lies past a shrunk window
          store_m[wpos_m] = raw;
          wpos_m = 4'((int'(wpos_m) + 1) % w);
          sum = 0;
          for (int i = 0; i < w; i++) sum += store_m[i];
          volt_m = 16'(sum / w);
        end
      end
    endcase
    return volt_m;
  endfunction

  // Sender gap: mostly none or short, a few long
  function automatic int pick_gap();
    int r;
    if (!idle_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // One input transfer; tvalid stays high for a following item without gap
  task automatic send_item(input logic [bvma_pkg::MODE_W-1:0] mode,
                           input logic [bvma_pkg::ADC_W-1:0] adc);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= mode;
    in_tdata  <= {6'd0, adc};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    volt_expected.push_back(predict_voltage(mode, adc));
    items_sent++;
  endtask

  // Stop sending and wait until every result has come back
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (volt_expected.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Write all four registers while the block is idle
  task automatic apply_settings(input logic en,
                                input logic [bvma_pkg::GAIN_W-1:0] gain,
                                input logic [bvma_pkg::WIN_W-1:0]  win,
                                input logic [bvma_pkg::CELL_W-1:0] cells);
    logic [15:0] junk;
    wait_idle();
    junk = 16'($urandom);
    cfg_wen   <= 1'b1;
    cfg_addr  <= bvma_pkg::REG_MONITOR_EN;
    cfg_wdata <= {junk[15:1], en};
    @(posedge clk);
    mon_en_m  = en;
    cfg_addr  <= bvma_pkg::REG_CAL_GAIN;
    cfg_wdata <= gain;
    @(posedge clk);
    gain_m    = gain;
    cfg_addr  <= bvma_pkg::REG_WINDOW_LEN;
    cfg_wdata <= {junk[10:0], win};
    @(posedge clk);
    win_m     = win;
    cfg_addr  <= bvma_pkg::REG_CELL_COUNT;
    cfg_wdata <= {junk[15:5], cells};
    @(posedge clk);
    cells_m   = cells;
    cfg_wen   <= 1'b0;
    settings_count++;
  endtask

  // Reset state: mode 3 returns the cleared estimate, then the cell default
  task automatic test_reset_state();
    send_item(MODE_NOP, 10'($urandom));
    send_item(bvma_pkg::MODE_INIT, 10'd1023);
  endtask

  // Monitor disabled: cell default, with zero cells and saturation
  task automatic test_cell_default();
    apply_settings(1'b0, bvma_pkg::GAIN_RST, bvma_pkg::WIN_RST, 5'd0);
    send_item(bvma_pkg::MODE_RESEED, 10'd1023);
    apply_settings(1'b0, bvma_pkg::GAIN_RST, 5'd4, 5'd31);
    send_item(bvma_pkg::MODE_UPDATE, 10'd0);
  endtask

  // Sample and gain extremes with a window of one
  task automatic test_scaling_extremes();
    apply_settings(1'b1, bvma_pkg::GAIN_RST, 5'd1, bvma_pkg::CELL_RST);
    send_item(bvma_pkg::MODE_INIT, 10'd0);
    send_item(bvma_pkg::MODE_INIT, 10'd1023);
    send_item(bvma_pkg::MODE_RESEED, 10'd1023);
    send_item(bvma_pkg::MODE_UPDATE, 10'd512);
    send_item(MODE_NOP, 10'd0);
    apply_settings(1'b1, 16'hFFFF, 5'd1, bvma_pkg::CELL_RST);
    send_item(bvma_pkg::MODE_INIT, 10'd1023);
    apply_settings(1'b1, 16'h0000, 5'd1, bvma_pkg::CELL_RST);
    send_item(bvma_pkg::MODE_UPDATE, 10'd1023);
  endtask

  // Averaging, window zero and clamp, position past a shrunk window
  task automatic test_window_handling();
    apply_settings(1'b1, bvma_pkg::GAIN_RST, 5'd4, bvma_pkg::CELL_RST);
    send_item(bvma_pkg::MODE_RESEED, 10'd300);
    send_item(bvma_pkg::MODE_UPDATE, 10'd1023);
    send_item(bvma_pkg::MODE_UPDATE, 10'd0);
    send_item(bvma_pkg::MODE_UPDATE, 10'd700);
    apply_settings(1'b1, bvma_pkg::GAIN_RST, 5'd0, bvma_pkg::CELL_RST);
    send_item(bvma_pkg::MODE_UPDATE, 10'd100);
    apply_settings(1'b1, bvma_pkg::GAIN_RST, 5'd31, bvma_pkg::CELL_RST);
    send_item(bvma_pkg::MODE_UPDATE, 10'd1023);
    send_item(bvma_pkg::MODE_UPDATE, 10'd5);
    apply_settings(1'b1, bvma_pkg::GAIN_RST, 5'd3, bvma_pkg::CELL_RST);
    send_item(bvma_pkg::MODE_UPDATE, 10'd850);
    send_item(MODE_NOP, 10'd1023);
  endtask

  // Receiver holds off long while items keep coming, then sender drains
  task automatic test_backpressure();
    apply_settings(1'b1, 16'd4500, 5'd16, bvma_pkg::CELL_RST);
    idle_on = 1'b0;
    hold_req = 1'b1;
    send_item(bvma_pkg::MODE_RESEED, 10'($urandom));
    repeat (11) send_item(bvma_pkg::MODE_UPDATE, 10'($urandom));
    wait_idle();
    idle_on = 1'b1;
  endtask

  // Random item: mostly updates after a reseed, some other modes
  task automatic send_random_item();
    int                          r;
    logic [bvma_pkg::MODE_W-1:0] mode;
    logic [bvma_pkg::ADC_W-1:0]  adc;
    r = $urandom_range(0, 99);
    if (r < 72)      mode = bvma_pkg::MODE_UPDATE;
    else if (r < 82) mode = bvma_pkg::MODE_INIT;
    else if (r < 91) mode = bvma_pkg::MODE_RESEED;
    else             mode = MODE_NOP;
    r = $urandom_range(0, 99);
    if (r < 5)       adc = 10'd0;
    else if (r < 10) adc = 10'd1023;
    else             adc = 10'($urandom);
    send_item(mode, adc);
  endtask

  // Random phases over many register settings
  task automatic test_random_traffic();
    logic                        en;
    logic [bvma_pkg::GAIN_W-1:0] gain;
    logic [bvma_pkg::WIN_W-1:0]  win;
    logic [bvma_pkg::CELL_W-1:0] cells;
    int                          r;
    for (int p = 0; p < RAND_PHASES; p++) begin
      en = ($urandom_range(0, 99) < 85);
      r = $urandom_range(0, 5);
      case (r)
        0:       gain = bvma_pkg::GAIN_RST;
        1:       gain = 16'($urandom_range(3500, 4700));
        2:       gain = 16'($urandom);
        3:       gain = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
        default: gain = 16'($urandom_range(2000, 6000));
      endcase
      r = $urandom_range(0, 99);
      if (r < 70)      win = 5'($urandom_range(2, 16));
      else if (r < 80) win = 5'd1;
      else if (r < 88) win = 5'd0;
      else             win = 5'($urandom_range(17, 31));
      cells = 5'($urandom_range(0, 31));
      // first two phases pin the extremes
      if (p == 0) begin
        en = 1'b1; gain = 16'hFFFF; win = 5'd16; cells = 5'd31;
      end else if (p == 1) begin
        en = 1'b1; gain = 16'h0000; win = 5'd1; cells = 5'd16;
      end
      apply_settings(en, gain, win, cells);
      idle_on = (p % 3 != 2);
      send_item(bvma_pkg::MODE_RESEED, 10'($urandom));
      repeat (PHASE_ITEMS - 1) send_random_item();
    end
    idle_on = 1'b1;
  endtask

  // Receiver: random stalls, long hold on request
  initial begin
    int stall_left;
    int r;
    stall_left = 0;
    out_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_tready <= 1'b0;
        hold_req = 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (!idle_on) begin
        out_tready <= 1'b1;
      end else if (stall_left > 0) begin
        out_tready <= 1'b0;
        stall_left--;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 70) begin
          out_tready <= 1'b1;
        end else begin
          stall_left = (r < 94) ? $urandom_range(0, 2) : $urandom_range(20, 80);
          out_tready <= 1'b0;
        end
      end
    end
  end

  // Result check against the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      if (volt_expected.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %0d", $time, out_tdata);
        errors++;
      end else begin
        volt_head = volt_expected.pop_front();
        if (out_tdata !== volt_head) begin
          $display("%0t: voltage_mv mismatch, expected %0d, actual %0d",
                   $time, volt_head, out_tdata);
          errors++;
        end
      end
    end
  end

  // Main sequence
  initial begin
    foreach (store_m[i]) store_m[i] = '0;
    rst_n     = 1'b0;
    cfg_wen   = 1'b0;
    cfg_addr  = '0;
    cfg_wdata = '0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_state();
    test_cell_default();
    test_scaling_extremes();
    test_window_handling();
    test_backpressure();
    test_random_traffic();

    wait_idle();
    repeat (20) @(posedge clk);
    $display("Covered %0d input transfers and %0d results over %0d register settings,",
             items_sent, results_seen, settings_count);
    $display("including all modes, window clamp and wrap, saturation and a long stall.");
    if (errors == 0 && volt_expected.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
